### rtl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every clock edge outside reset
`define KGAS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every clock edge, reset included
`define KGAS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### rtl/kgas_pkg.sv
// shared types and constants of the keypoint grid area search
package kgas_pkg;

    localparam int FRAC_W  = 24;
    localparam int PROD_W  = 43;
    localparam int CRD_W   = PROD_W - FRAC_W;
    localparam int POINT_W = 11;
    localparam int PT_W    = 35;

    localparam logic [1:0] FUNC_CLEAR  = 2'd0;
    localparam logic [1:0] FUNC_INSERT = 2'd1;
    localparam logic [1:0] FUNC_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_OUTSIDE    = 2'd1;
    localparam logic [1:0] ST_CELL_FULL  = 2'd2;
    localparam logic [1:0] ST_STORE_FULL = 2'd3;

    localparam logic [1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [1:0] CFG_SCALE_X  = 2'd2;
    localparam logic [1:0] CFG_SCALE_Y  = 2'd3;

    localparam logic [23:0] SCALE_RESET = 24'd104858;

    localparam logic signed [PROD_W-1:0] CEIL_BIAS    = PROD_W'(24'hFFFFFF);
    localparam logic signed [PROD_W-1:0] RND_BIAS_POS = PROD_W'(24'h800000);
    localparam logic signed [PROD_W-1:0] RND_BIAS_NEG = PROD_W'(24'h7FFFFF);

    localparam logic [2:0] MS_DX  = 3'd0;
    localparam logic [2:0] MS_DY  = 3'd1;
    localparam logic [2:0] MS_XLO = 3'd2;
    localparam logic [2:0] MS_XHI = 3'd3;
    localparam logic [2:0] MS_YLO = 3'd4;
    localparam logic [2:0] MS_YHI = 3'd5;

    localparam logic [2:0] RS_NONE = 3'd0;
    localparam logic [2:0] RS_CX   = 3'd1;
    localparam logic [2:0] RS_CY   = 3'd2;
    localparam logic [2:0] RS_X0   = 3'd3;
    localparam logic [2:0] RS_X1   = 3'd4;
    localparam logic [2:0] RS_Y0   = 3'd5;
    localparam logic [2:0] RS_Y1   = 3'd6;

    localparam logic [2:0] PK_ZERO      = 3'd0;
    localparam logic [2:0] PK_FULL      = 3'd1;
    localparam logic [2:0] PK_OUTSIDE   = 3'd2;
    localparam logic [2:0] PK_CELL_FULL = 3'd3;
    localparam logic [2:0] PK_OK        = 3'd4;
    localparam logic [2:0] PK_HIT       = 3'd5;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [2:0]         level;
        logic [15:0]        half_width;
        logic [2:0]         level_min;
        logic signed [3:0]  level_max;
    } t_in_word;

    typedef struct packed {
        logic [POINT_W-1:0] point_index;
        logic               found;
        logic [1:0]         status;
        logic               truncated;
        logic               last;
    } t_out_word;

    typedef struct packed {
        logic [1:0]  index;
        logic [23:0] value;
    } t_cfg_word;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [2:0]         level;
    } t_pt_word;

    typedef struct packed {
        logic       load;
        logic       clr_start;
        logic       sweep_step;
        logic       ins_store;
        logic       mul_go;
        logic [2:0] mul_sel;
        logic [2:0] rnd_sel;
        logic       ins_cell_rd;
        logic       ins_file;
        logic       q_init;
        logic       q_cell_rd;
        logic       q_fill_latch;
        logic       q_ent_rd;
        logic       q_pt_rd;
        logic       q_test;
        logic       q_next;
        logic       hit_rd;
        logic       push;
        logic [2:0] push_kind;
    } t_ctl_cmd;

    typedef struct packed {
        logic full;
        logic outside;
        logic cell_full;
        logic span_empty;
        logic ent_done;
        logic last_row;
        logic last_col;
        logic hit_none;
        logic hit_last;
        logic sweep_last;
        logic out_free;
    } t_ctl_stat;

endpackage

### rtl/kgas_stream_if.sv
// valid/ready channel carrying one word of a given type
interface kgas_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/kgas_ram.sv
// generic simple dual port ram with registered read
module kgas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/kgas_datapath.sv
// datapath: stores, multiplier, cell walk counters and output register
`include "assert_macros.svh"
module kgas_datapath #(
    parameter int GRID_COLS     = 64,
    parameter int GRID_ROWS     = 48,
    parameter int MAX_POINTS    = 2048,
    parameter int CELL_CAPACITY = 16,
    parameter int MAX_HITS      = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kgas_pkg::t_ctl_cmd  i_cmd,
    output kgas_pkg::t_ctl_stat o_stat,
    input  kgas_pkg::t_in_word  i_in_data,
    input  logic                i_cfg_we,
    input  kgas_pkg::t_cfg_word i_cfg_data,
    output logic                o_out_valid,
    output kgas_pkg::t_out_word o_out_data,
    input  logic                i_out_ready
);
    import kgas_pkg::*;

    localparam int NCELLS = GRID_COLS * GRID_ROWS;
    localparam int NENT   = NCELLS * CELL_CAPACITY;
    localparam int CW     = (NCELLS > 1) ? $clog2(NCELLS) : 1;
    localparam int EW     = (NENT > 1) ? $clog2(NENT) : 1;
    localparam int IW     = $clog2(MAX_POINTS);
    localparam int NW     = $clog2(MAX_POINTS + 1);
    localparam int FW     = $clog2(CELL_CAPACITY + 1);
    localparam int HAW    = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam int HNW    = $clog2(MAX_HITS + 1);
    localparam int CXW    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int CYW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;

    localparam logic signed [CRD_W-1:0] COLS_S    = CRD_W'(GRID_COLS);
    localparam logic signed [CRD_W-1:0] ROWS_S    = CRD_W'(GRID_ROWS);
    localparam logic signed [CRD_W-1:0] COLS_M1_S = CRD_W'(GRID_COLS - 1);
    localparam logic signed [CRD_W-1:0] ROWS_M1_S = CRD_W'(GRID_ROWS - 1);

    logic signed [15:0]       r_org_x, r_org_y;
    logic [23:0]              r_scl_x, r_scl_y;
    t_in_word                 r_in;
    logic [NW-1:0]            r_count;
    logic [IW-1:0]            r_idx;
    logic [CW-1:0]            r_sweep;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [CRD_W-1:0]  r_cx, r_cy, r_x0, r_x1, r_y0, r_y1;
    logic [CXW-1:0]           r_ix, r_x1c;
    logic [CYW-1:0]           r_iy, r_y0c, r_y1c;
    logic [CW-1:0]            r_cell;
    logic [FW-1:0]            r_fill, r_j;
    logic [HNW-1:0]           r_n, r_k;
    logic                     r_trunc;
    logic                     r_out_valid;
    t_out_word                r_out_word;

    logic signed [16:0]       dx, dy, ex, ey;
    logic [16:0]              ax, ay;
    logic signed [17:0]       rhalf, mul_a;
    logic signed [24:0]       mul_b;
    logic signed [PROD_W-1:0] sum_ceil, sum_rnd;
    logic signed [CRD_W-1:0]  q_floor, q_ceil, q_rnd;
    logic [CW-1:0]            ins_cell, walk_cell;
    logic [FW-1:0]            fill_rdata;
    logic [IW-1:0]            ent_rdata, hit_rdata;
    logic [PT_W-1:0]          pt_rdata;
    t_pt_word                 pt;
    logic                     match, lvl_ok, hit_room, out_free;
    t_out_word                push_word;

    // multiplier operands
    assign dx    = $signed({r_in.pos_x[15], r_in.pos_x}) - $signed({r_org_x[15], r_org_x});
    assign dy    = $signed({r_in.pos_y[15], r_in.pos_y}) - $signed({r_org_y[15], r_org_y});
    assign rhalf = $signed({2'b00, r_in.half_width});

    always_comb begin
        unique case (i_cmd.mul_sel)
            MS_DX: begin
                mul_a = {dx[16], dx};
                mul_b = $signed({1'b0, r_scl_x});
            end
            MS_DY: begin
                mul_a = {dy[16], dy};
                mul_b = $signed({1'b0, r_scl_y});
            end
            MS_XLO: begin
                mul_a = $signed({dx[16], dx}) - rhalf;
                mul_b = $signed({1'b0, r_scl_x});
            end
            MS_XHI: begin
                mul_a = $signed({dx[16], dx}) + rhalf;
                mul_b = $signed({1'b0, r_scl_x});
            end
            MS_YLO: begin
                mul_a = $signed({dy[16], dy}) - rhalf;
                mul_b = $signed({1'b0, r_scl_y});
            end
            MS_YHI: begin
                mul_a = $signed({dy[16], dy}) + rhalf;
                mul_b = $signed({1'b0, r_scl_y});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // cell index rounding from the registered product
    assign sum_ceil = r_prod + CEIL_BIAS;
    assign sum_rnd  = r_prod + (r_prod[PROD_W-1] ? RND_BIAS_NEG : RND_BIAS_POS);
    assign q_floor  = r_prod[PROD_W-1:FRAC_W];
    assign q_ceil   = sum_ceil[PROD_W-1:FRAC_W];
    assign q_rnd    = sum_rnd[PROD_W-1:FRAC_W];

    assign ins_cell  = CW'(r_cx[CXW-1:0]) * CW'(GRID_ROWS) + CW'(r_cy[CYW-1:0]);
    assign walk_cell = CW'(r_ix) * CW'(GRID_ROWS) + CW'(r_iy);

    // point test
    assign pt     = t_pt_word'(pt_rdata);
    assign ex     = $signed({pt.pos_x[15], pt.pos_x}) - $signed({r_in.pos_x[15], r_in.pos_x});
    assign ey     = $signed({pt.pos_y[15], pt.pos_y}) - $signed({r_in.pos_y[15], r_in.pos_y});
    assign ax     = ex[16] ? 17'(-ex) : 17'(ex);
    assign ay     = ey[16] ? 17'(-ey) : 17'(ey);
    assign lvl_ok = (pt.level >= r_in.level_min) &&
                    (r_in.level_max[3] || (pt.level <= r_in.level_max[2:0]));
    assign match  = lvl_ok && (ax < {1'b0, r_in.half_width}) && (ay < {1'b0, r_in.half_width});
    assign hit_room = r_n < HNW'(MAX_HITS);

    kgas_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_pt_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_store),
        .i_waddr (r_count[IW-1:0]),
        .i_wdata ({r_in.pos_x, r_in.pos_y, r_in.level}),
        .i_re    (i_cmd.q_pt_rd),
        .i_raddr (ent_rdata),
        .o_rdata (pt_rdata)
    );

    kgas_ram #(.WIDTH(FW), .DEPTH(NCELLS)) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.sweep_step | i_cmd.ins_file),
        .i_waddr (i_cmd.sweep_step ? r_sweep : r_cell),
        .i_wdata (i_cmd.sweep_step ? FW'(0) : fill_rdata + FW'(1)),
        .i_re    (i_cmd.ins_cell_rd | i_cmd.q_cell_rd),
        .i_raddr (i_cmd.ins_cell_rd ? ins_cell : walk_cell),
        .o_rdata (fill_rdata)
    );

    kgas_ram #(.WIDTH(IW), .DEPTH(NENT)) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_file),
        .i_waddr (EW'(r_cell) * EW'(CELL_CAPACITY) + EW'(fill_rdata)),
        .i_wdata (r_idx),
        .i_re    (i_cmd.q_ent_rd),
        .i_raddr (EW'(r_cell) * EW'(CELL_CAPACITY) + EW'(r_j)),
        .o_rdata (ent_rdata)
    );

    kgas_ram #(.WIDTH(IW), .DEPTH(MAX_HITS)) u_hit_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.q_test & match & hit_room),
        .i_waddr (r_n[HAW-1:0]),
        .i_wdata (r_idx),
        .i_re    (i_cmd.hit_rd),
        .i_raddr (r_k[HAW-1:0]),
        .o_rdata (hit_rdata)
    );

    // result word
    always_comb begin
        push_word             = '0;
        push_word.point_index = POINT_W'(r_idx);
        push_word.found       = 1'b1;
        push_word.last        = 1'b1;
        unique case (i_cmd.push_kind)
            PK_ZERO: begin
                push_word.point_index = '0;
                push_word.found       = 1'b0;
            end
            PK_FULL: begin
                push_word.point_index = '0;
                push_word.found       = 1'b0;
                push_word.status      = ST_STORE_FULL;
            end
            PK_OUTSIDE:   push_word.status = ST_OUTSIDE;
            PK_CELL_FULL: push_word.status = ST_CELL_FULL;
            PK_OK:        push_word.status = ST_OK;
            PK_HIT: begin
                push_word.point_index = POINT_W'(hit_rdata);
                push_word.truncated   = r_trunc;
                push_word.last        = o_stat.hit_last;
            end
            default: push_word = '0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x     <= '0;
            r_org_y     <= '0;
            r_scl_x     <= SCALE_RESET;
            r_scl_y     <= SCALE_RESET;
            r_count     <= '0;
            r_sweep     <= '0;
            r_n         <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_data.index)
                    CFG_ORIGIN_X: r_org_x <= i_cfg_data.value[15:0];
                    CFG_ORIGIN_Y: r_org_y <= i_cfg_data.value[15:0];
                    CFG_SCALE_X:  r_scl_x <= i_cfg_data.value;
                    CFG_SCALE_Y:  r_scl_y <= i_cfg_data.value;
                endcase
            end
            if (i_cmd.clr_start) begin
                r_count <= '0;
                r_sweep <= '0;
            end
            if (i_cmd.sweep_step) begin
                r_sweep <= r_sweep + CW'(1);
            end
            if (i_cmd.ins_store) begin
                r_count <= r_count + NW'(1);
            end
            if (i_cmd.q_init) begin
                r_n <= '0;
                r_k <= '0;
            end
            if (i_cmd.q_test && match && hit_room) begin
                r_n <= r_n + HNW'(1);
            end
            if (i_cmd.push && i_cmd.push_kind == PK_HIT) begin
                r_k <= r_k + HNW'(1);
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_data;
        end
        if (i_cmd.ins_store) begin
            r_idx <= r_count[IW-1:0];
        end
        if (i_cmd.q_pt_rd) begin
            r_idx <= ent_rdata;
        end
        if (i_cmd.mul_go) begin
            r_prod <= mul_a * mul_b;
        end
        unique case (i_cmd.rnd_sel)
            RS_CX:   r_cx <= q_rnd;
            RS_CY:   r_cy <= q_rnd;
            RS_X0:   r_x0 <= q_floor;
            RS_X1:   r_x1 <= q_ceil;
            RS_Y0:   r_y0 <= q_floor;
            RS_Y1:   r_y1 <= q_ceil;
            default: ;
        endcase
        if (i_cmd.ins_cell_rd) begin
            r_cell <= ins_cell;
        end
        if (i_cmd.q_cell_rd) begin
            r_cell <= walk_cell;
        end
        if (i_cmd.q_init) begin
            r_ix    <= r_x0[CRD_W-1] ? '0 : r_x0[CXW-1:0];
            r_x1c   <= (r_x1 > COLS_M1_S) ? CXW'(GRID_COLS - 1) : r_x1[CXW-1:0];
            r_iy    <= r_y0[CRD_W-1] ? '0 : r_y0[CYW-1:0];
            r_y0c   <= r_y0[CRD_W-1] ? '0 : r_y0[CYW-1:0];
            r_y1c   <= (r_y1 > ROWS_M1_S) ? CYW'(GRID_ROWS - 1) : r_y1[CYW-1:0];
            r_trunc <= 1'b0;
        end
        if (i_cmd.q_fill_latch) begin
            r_fill <= fill_rdata;
            r_j    <= '0;
        end
        if (i_cmd.q_ent_rd) begin
            r_j <= r_j + FW'(1);
        end
        if (i_cmd.q_test && match && !hit_room) begin
            r_trunc <= 1'b1;
        end
        if (i_cmd.q_next) begin
            if (o_stat.last_row) begin
                r_ix <= r_ix + CXW'(1);
                r_iy <= r_y0c;
            end else begin
                r_iy <= r_iy + CYW'(1);
            end
        end
        if (i_cmd.push) begin
            r_out_word <= push_word;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat            = '0;
        o_stat.full       = r_count >= NW'(MAX_POINTS);
        o_stat.outside    = r_cx[CRD_W-1] || (r_cx >= COLS_S) || r_cy[CRD_W-1] || (r_cy >= ROWS_S);
        o_stat.cell_full  = fill_rdata >= FW'(CELL_CAPACITY);
        o_stat.span_empty = (r_x0 >= COLS_S) || r_x1[CRD_W-1] ||
                            (r_y0 >= ROWS_S) || r_y1[CRD_W-1];
        o_stat.ent_done   = r_j == r_fill;
        o_stat.last_row   = r_iy == r_y1c;
        o_stat.last_col   = r_ix == r_x1c;
        o_stat.hit_none   = r_n == '0;
        o_stat.hit_last   = (r_k + HNW'(1)) == r_n;
        o_stat.sweep_last = r_sweep == CW'(NCELLS - 1);
        o_stat.out_free   = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_word;

    `KGAS_ASSERT(a_hits_bounded, r_n <= HNW'(MAX_HITS), "hit count beyond buffer")
    `KGAS_ASSERT(a_file_room, i_cmd.ins_file |-> !o_stat.cell_full, "filing into a full cell")
    `KGAS_ASSERT(a_out_hold, r_out_valid && !i_out_ready |=> r_out_valid && $stable(r_out_word), "waiting word changed")
endmodule

### rtl/kgas_ctrl.sv
// controller: sequences clear, insert, query walk and result delivery
`include "assert_macros.svh"
module kgas_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [1:0]          i_in_func,
    input  kgas_pkg::t_ctl_stat i_stat,
    output logic                o_in_ready,
    output kgas_pkg::t_ctl_cmd  o_cmd
);
    import kgas_pkg::*;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_SWEEP    = 5'd1;
    localparam logic [4:0] S_INS0     = 5'd2;
    localparam logic [4:0] S_INS_MY   = 5'd3;
    localparam logic [4:0] S_INS_RY   = 5'd4;
    localparam logic [4:0] S_INS_CELL = 5'd5;
    localparam logic [4:0] S_INS_FILL = 5'd6;
    localparam logic [4:0] S_Q_M0     = 5'd7;
    localparam logic [4:0] S_Q_M1     = 5'd8;
    localparam logic [4:0] S_Q_M2     = 5'd9;
    localparam logic [4:0] S_Q_M3     = 5'd10;
    localparam logic [4:0] S_Q_M4     = 5'd11;
    localparam logic [4:0] S_Q_CHK    = 5'd12;
    localparam logic [4:0] S_Q_CELL   = 5'd13;
    localparam logic [4:0] S_Q_FILL   = 5'd14;
    localparam logic [4:0] S_Q_ERD    = 5'd15;
    localparam logic [4:0] S_Q_ENT    = 5'd16;
    localparam logic [4:0] S_Q_TEST   = 5'd17;
    localparam logic [4:0] S_Q_NEXT   = 5'd18;
    localparam logic [4:0] S_Q_DONE   = 5'd19;
    localparam logic [4:0] S_EMIT_RD  = 5'd20;
    localparam logic [4:0] S_EMIT     = 5'd21;
    localparam logic [4:0] S_PUSH     = 5'd22;

    logic [4:0] r_state, n_state;
    logic [2:0] r_pk, n_pk;
    logic       r_clr_rsp, n_clr_rsp;

    always_comb begin
        n_state    = r_state;
        n_pk       = r_pk;
        n_clr_rsp  = r_clr_rsp;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_in_func)
                        FUNC_CLEAR: begin
                            o_cmd.clr_start = 1'b1;
                            n_clr_rsp       = 1'b1;
                            n_state         = S_SWEEP;
                        end
                        FUNC_INSERT: n_state = S_INS0;
                        FUNC_QUERY:  n_state = S_Q_M0;
                        default:     n_state = S_IDLE;
                    endcase
                end
            end
            S_SWEEP: begin
                o_cmd.sweep_step = 1'b1;
                if (i_stat.sweep_last) begin
                    if (r_clr_rsp) begin
                        n_pk    = PK_ZERO;
                        n_state = S_PUSH;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_INS0: begin
                if (i_stat.full) begin
                    n_pk    = PK_FULL;
                    n_state = S_PUSH;
                end else begin
                    o_cmd.ins_store = 1'b1;
                    o_cmd.mul_go    = 1'b1;
                    o_cmd.mul_sel   = MS_DX;
                    n_state         = S_INS_MY;
                end
            end
            S_INS_MY: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MS_DY;
                o_cmd.rnd_sel = RS_CX;
                n_state       = S_INS_RY;
            end
            S_INS_RY: begin
                o_cmd.rnd_sel = RS_CY;
                n_state       = S_INS_CELL;
            end
            S_INS_CELL: begin
                if (i_stat.outside) begin
                    n_pk    = PK_OUTSIDE;
                    n_state = S_PUSH;
                end else begin
                    o_cmd.ins_cell_rd = 1'b1;
                    n_state           = S_INS_FILL;
                end
            end
            S_INS_FILL: begin
                if (i_stat.cell_full) begin
                    n_pk = PK_CELL_FULL;
                end else begin
                    o_cmd.ins_file = 1'b1;
                    n_pk           = PK_OK;
                end
                n_state = S_PUSH;
            end
            S_Q_M0: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MS_XLO;
                n_state       = S_Q_M1;
            end
            S_Q_M1: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MS_XHI;
                o_cmd.rnd_sel = RS_X0;
                n_state       = S_Q_M2;
            end
            S_Q_M2: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MS_YLO;
                o_cmd.rnd_sel = RS_X1;
                n_state       = S_Q_M3;
            end
            S_Q_M3: begin
                o_cmd.mul_go  = 1'b1;
                o_cmd.mul_sel = MS_YHI;
                o_cmd.rnd_sel = RS_Y0;
                n_state       = S_Q_M4;
            end
            S_Q_M4: begin
                o_cmd.rnd_sel = RS_Y1;
                n_state       = S_Q_CHK;
            end
            S_Q_CHK: begin
                o_cmd.q_init = 1'b1;
                n_state      = i_stat.span_empty ? S_Q_DONE : S_Q_CELL;
            end
            S_Q_CELL: begin
                o_cmd.q_cell_rd = 1'b1;
                n_state         = S_Q_FILL;
            end
            S_Q_FILL: begin
                o_cmd.q_fill_latch = 1'b1;
                n_state            = S_Q_ERD;
            end
            S_Q_ERD: begin
                if (i_stat.ent_done) begin
                    n_state = S_Q_NEXT;
                end else begin
                    o_cmd.q_ent_rd = 1'b1;
                    n_state        = S_Q_ENT;
                end
            end
            S_Q_ENT: begin
                o_cmd.q_pt_rd = 1'b1;
                n_state       = S_Q_TEST;
            end
            S_Q_TEST: begin
                o_cmd.q_test = 1'b1;
                n_state      = S_Q_ERD;
            end
            S_Q_NEXT: begin
                if (i_stat.last_row && i_stat.last_col) begin
                    n_state = S_Q_DONE;
                end else begin
                    o_cmd.q_next = 1'b1;
                    n_state      = S_Q_CELL;
                end
            end
            S_Q_DONE: begin
                if (i_stat.hit_none) begin
                    n_pk    = PK_ZERO;
                    n_state = S_PUSH;
                end else begin
                    n_state = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                o_cmd.hit_rd = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_kind = PK_HIT;
                    n_state         = i_stat.hit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            S_PUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.push      = 1'b1;
                    o_cmd.push_kind = r_pk;
                    n_state         = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_SWEEP;
            r_pk      <= PK_ZERO;
            r_clr_rsp <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pk      <= n_pk;
            r_clr_rsp <= n_clr_rsp;
        end
    end

    `KGAS_ASSERT_ALWAYS(a_reset_sweep, !i_rst_n |=> r_state == S_SWEEP, "no clearing pass after reset")
    `KGAS_ASSERT(a_push_free, o_cmd.push |-> i_stat.out_free, "word pushed over a waiting word")
    `KGAS_ASSERT(a_test_after_read, o_cmd.q_test |-> $past(o_cmd.q_pt_rd), "point tested without read")
endmodule

### rtl/keypoint_grid_area_search.sv
// keypoint grid area search: uniform grid index of feature points with square area queries
// One word at a time. After reset, and for every clear, the cell fill table is swept one cell
// per cycle through the whole table, with the input held off; a clear then gives its word.
// An insert gives its result word, also when the store is full or the point falls outside
// the grid. A query bounds the cell span with one shared multiplier, then walks each covered
// cell, reading its fill and, for each filed entry, the entry and point memories, and then
// delivers one word per hit, or one word for an empty result.
// A result word still waiting at the output holds off the next one. Configuration writes are
// taken in any cycle and should be made while idle.
module keypoint_grid_area_search #(
    parameter int GRID_COLS     = 64,
    parameter int GRID_ROWS     = 48,
    parameter int MAX_POINTS    = 2048,
    parameter int CELL_CAPACITY = 16,
    parameter int MAX_HITS      = 64
) (
    input logic           i_clk,
    input logic           i_rst_n,
    kgas_stream_if.sink   i_in,
    kgas_stream_if.source o_out,
    kgas_stream_if.sink   i_cfg
);
    import kgas_pkg::*;

    t_ctl_cmd  cmd;
    t_ctl_stat stat;
    logic      in_ready;
    logic      out_valid;
    t_out_word out_data;

    kgas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_func  (i_in.data.func),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    kgas_datapath #(
        .GRID_COLS     (GRID_COLS),
        .GRID_ROWS     (GRID_ROWS),
        .MAX_POINTS    (MAX_POINTS),
        .CELL_CAPACITY (CELL_CAPACITY),
        .MAX_HITS      (MAX_HITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in.data),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_ready (o_out.ready)
    );

    assign i_in.ready  = in_ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = out_valid;
    assign o_out.data  = out_data;
endmodule
